### hdl/act_pkg.sv
// Shared types, constants and helpers for the alignment column tagger.
package act_pkg;

    localparam logic [3:0] INSERT_CAP = 4'd12;
    localparam logic [7:0] GAP_CHAR   = 8'h2D;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ID      = 2'd2;

    typedef struct packed {
        logic [7:0] query_char;
        logic [7:0] target_char;
        logic       first_column;
        logic       last_column;
    } t_column;

    typedef struct packed {
        logic [30:0]        target_start;
        logic signed [31:0] target_offset;
        logic [31:0]        query_id;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        tag_target_pos;
        logic [7:0]         tag_delta;
        logic signed [31:0] prev_target_pos;
        logic [3:0]         prev_delta;
        logic [7:0]         prev_base;
        logic [7:0]         cur_base;
        logic [31:0]        tag_query_id;
        logic               is_sentinel;
        logic               last_result;
    } t_result;

    function automatic t_result sentinel_result();
        t_result s;
        s.tag_target_pos  = '1;
        s.tag_delta       = 8'hFF;
        s.prev_target_pos = '0;
        s.prev_delta      = '0;
        s.prev_base       = '0;
        s.cur_base        = DOT_CHAR;
        s.tag_query_id    = '1;
        s.is_sentinel     = 1'b1;
        s.last_result     = 1'b1;
        return s;
    endfunction

endpackage

### hdl/act_column_core.sv
// Tag state registers and the per-column tag computation.
module act_column_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  act_pkg::t_column i_col,
    input  act_pkg::t_cfg    i_cfg,
    output logic             o_emit,
    output logic             o_sent_follow,
    output act_pkg::t_result o_res
);
    import act_pkg::*;

    logic [31:0] r_cursor, n_cursor;
    logic [3:0]  r_run, n_run;
    logic [31:0] r_prev_cursor, n_prev_cursor;
    logic [3:0]  r_prev_run, n_prev_run;
    logic [7:0]  r_prev_char, n_prev_char;
    logic        r_halted, n_halted;

    logic [31:0] b_cursor, b_prev_cursor;
    logic [3:0]  b_run, b_prev_run, run_q;
    logic [7:0]  b_prev_char;
    logic        halted_eff, neg;
    logic [32:0] pos;

    always_comb begin
        // first column reloads the state before it is processed
        b_cursor      = i_col.first_column ? ({1'b0, i_cfg.target_start} - 32'd1) : r_cursor;
        b_run         = i_col.first_column ? 4'd0 : r_run;
        b_prev_cursor = i_col.first_column ? 32'hFFFF_FFFF : r_prev_cursor;
        b_prev_run    = i_col.first_column ? 4'd0 : r_prev_run;
        b_prev_char   = i_col.first_column ? DOT_CHAR : r_prev_char;
        halted_eff    = i_col.first_column ? 1'b0 : r_halted;

        run_q = ((i_col.query_char != GAP_CHAR) && (b_run < INSERT_CAP)) ? b_run + 4'd1 : b_run;
        if (i_col.target_char != GAP_CHAR) begin
            n_cursor = b_cursor + 32'd1;
            n_run    = 4'd0;
        end else begin
            n_cursor = b_cursor;
            n_run    = run_q;
        end

        // exact 33-bit sum; sign bit flags a negative position
        pos = {n_cursor[31], n_cursor} + {i_cfg.target_offset[31], i_cfg.target_offset};
        neg = pos[32];

        n_prev_cursor = neg ? b_prev_cursor : n_cursor;
        n_prev_run    = neg ? b_prev_run    : n_run;
        n_prev_char   = neg ? b_prev_char   : i_col.query_char;
        n_halted      = neg || i_col.last_column;

        if (neg) begin
            o_res = sentinel_result();
        end else begin
            o_res.tag_target_pos  = pos[31:0];
            o_res.tag_delta       = {4'd0, n_run};
            o_res.prev_target_pos = b_prev_cursor + i_cfg.target_offset;
            o_res.prev_delta      = b_prev_run;
            o_res.prev_base       = b_prev_char;
            o_res.cur_base        = i_col.query_char;
            o_res.tag_query_id    = i_cfg.query_id;
            o_res.is_sentinel     = 1'b0;
            o_res.last_result     = !i_col.last_column;
        end

        o_emit        = i_fire && !halted_eff;
        o_sent_follow = !neg && i_col.last_column;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor      <= 32'hFFFF_FFFF;
            r_run         <= 4'd0;
            r_prev_cursor <= 32'hFFFF_FFFF;
            r_prev_run    <= 4'd0;
            r_prev_char   <= DOT_CHAR;
            r_halted      <= 1'b0;
        end else if (i_fire && !halted_eff) begin
            r_cursor      <= n_cursor;
            r_run         <= n_run;
            r_prev_cursor <= n_prev_cursor;
            r_prev_run    <= n_prev_run;
            r_prev_char   <= n_prev_char;
            r_halted      <= n_halted;
        end
    end

endmodule

### hdl/act_result_buf.sv
// Result register with a pending end-of-alignment sentinel slot.
module act_result_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  act_pkg::t_result i_res,
    input  logic             i_sent_follow,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_free,
    output act_pkg::t_result o_res
);
    import act_pkg::*;

    logic    r_valid;
    logic    r_pend;
    t_result r_res;
    logic    drain;

    assign drain   = r_valid && !i_stall;
    assign o_free  = !r_valid || (!i_stall && !r_pend);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (drain && r_pend) begin
            r_pend <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_pend  <= i_sent_follow;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain && r_pend) begin
            r_res <= sentinel_result();
        end else if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### hdl/alignment_column_tagger_unit.sv
// Top level of the alignment column tagger: input register, tag core, result buffer.
//
// Takes one alignment column per beat and gives one tag per column; a column
// marked last gives its tag and then a sentinel beat, and a column whose
// offset target position goes negative gives only a sentinel and halts
// tagging. While halted, columns are consumed with no result until a column
// with first_column set reloads the state from the configuration registers.
// Throughput is one column per clock while the output is not stalled; a last
// column holds the input while the result buffer sends its trailing sentinel.
// A tag passes the input register, then the result register. All work for a
// column is a 4-bit run counter, a 32-bit increment, a 33-bit add of the target
// offset and a 32-bit add for the previous position, all combinational between
// the two registers. Configuration writes are always taken (o_cfg_ready is
// tied high) and must only happen while the block is idle; index 3 is ignored.
module alignment_column_tagger_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // column input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_query_char,
    input  logic [7:0]                    i_target_char,
    input  logic                          i_first_column,
    input  logic                          i_last_column,
    // tag output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [31:0]                   o_tag_target_pos,
    output logic [7:0]                    o_tag_delta,
    output logic signed [31:0]            o_prev_target_pos,
    output logic [3:0]                    o_prev_delta,
    output logic [7:0]                    o_prev_base,
    output logic [7:0]                    o_cur_base,
    output logic [31:0]                   o_tag_query_id,
    output logic                          o_is_sentinel,
    output logic                          o_last_result,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [act_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import act_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_column r_col;

    logic    adv;
    logic    emit;
    logic    sent_follow;
    logic    buf_free;
    t_result core_res;
    t_result out_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_START:  r_cfg.target_start  <= i_cfg_data[30:0];
                CFG_TARGET_OFFSET: r_cfg.target_offset <= i_cfg_data;
                CFG_QUERY_ID:      r_cfg.query_id      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register: the column moves on once the result buffer has room
    assign adv        = r_in_valid && buf_free;
    assign o_in_stall = r_in_valid && !buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_col.query_char   <= i_query_char;
            r_col.target_char  <= i_target_char;
            r_col.first_column <= i_first_column;
            r_col.last_column  <= i_last_column;
        end
    end

    act_column_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (adv),
        .i_col         (r_col),
        .i_cfg         (r_cfg),
        .o_emit        (emit),
        .o_sent_follow (sent_follow),
        .o_res         (core_res)
    );

    act_result_buf u_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (emit),
        .i_res         (core_res),
        .i_sent_follow (sent_follow),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_free        (buf_free),
        .o_res         (out_res)
    );

    assign o_tag_target_pos  = out_res.tag_target_pos;
    assign o_tag_delta       = out_res.tag_delta;
    assign o_prev_target_pos = out_res.prev_target_pos;
    assign o_prev_delta      = out_res.prev_delta;
    assign o_prev_base       = out_res.prev_base;
    assign o_cur_base        = out_res.cur_base;
    assign o_tag_query_id    = out_res.tag_query_id;
    assign o_is_sentinel     = out_res.is_sentinel;
    assign o_last_result     = out_res.last_result;

endmodule

### hdl/act_checker.sv
// Port-level checker for the alignment column tagger and its bind.
module act_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [31:0]                   o_tag_target_pos,
    input  logic [7:0]                    o_tag_delta,
    input  logic [3:0]                    o_prev_delta,
    input  logic [7:0]                    o_cur_base,
    input  logic                          o_is_sentinel,
    input  logic                          o_last_result
);
    import act_pkg::*;

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tag_target_pos)
            && $stable(o_is_sentinel) && $stable(o_last_result))
        else $error("output beat changed while stalled");

    // sentinel beat carries its fixed fields and ends the column's results
    a_sentinel_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_sentinel |-> o_tag_target_pos == 32'hFFFF_FFFF
            && o_tag_delta == 8'hFF && o_last_result && o_cur_base == DOT_CHAR)
        else $error("malformed sentinel beat");

    // a tag that is not the final result is followed directly by the sentinel
    a_sentinel_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_sentinel && !o_last_result && !i_out_stall
            |=> o_out_valid && o_is_sentinel)
        else $error("sentinel missing after last-column tag");

    // run lengths stay within the insertion cap
    a_run_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_sentinel |-> o_tag_delta <= {4'd0, INSERT_CAP}
            && o_prev_delta <= INSERT_CAP)
        else $error("run length above cap");

endmodule

bind alignment_column_tagger_unit act_checker u_act_checker (.*);

### test/tb_alignment_column_tagger_unit.sv
// Testbench for alignment_column_tagger_unit: random column streams checked against a tag predictor.
module tb_alignment_column_tagger_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import act_pkg::*;

    // Watchdog. The slowest legal run has about 1100 columns, each with a long
    // send gap, two tags and a long output stall per tag.
    localparam int unsigned CYCLE_LIMIT = 800_000;
    // Cycles to let the pipeline settle when no tag is pending. Columns that
    // hit a halted tagger produce nothing, so the queue alone cannot show idle.
    localparam int unsigned SETTLE_CYCLES = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index, ignored

    localparam logic [7:0] BASE_A = 8'h41;
    localparam logic [7:0] BASE_C = 8'h43;
    localparam logic [7:0] BASE_G = 8'h47;
    localparam logic [7:0] BASE_T = 8'h54;

    // End-of-alignment marker beat.
    localparam t_result END_TAG = '{
        tag_target_pos:  32'hFFFF_FFFF,
        tag_delta:       8'hFF,
        prev_target_pos: 32'sd0,
        prev_delta:      4'd0,
        prev_base:       8'h00,
        cur_base:        DOT_CHAR,
        tag_query_id:    32'hFFFF_FFFF,
        is_sentinel:     1'b1,
        last_result:     1'b1
    };

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_query_char = '0;
    logic [7:0]           i_target_char = '0;
    logic                 i_first_column = 1'b0;
    logic                 i_last_column = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [31:0]          o_tag_target_pos;
    logic [7:0]           o_tag_delta;
    logic signed [31:0]   o_prev_target_pos;
    logic [3:0]           o_prev_delta;
    logic [7:0]           o_prev_base;
    logic [7:0]           o_cur_base;
    logic [31:0]          o_tag_query_id;
    logic                 o_is_sentinel;
    logic                 o_last_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    alignment_column_tagger_unit i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tag predictor: shadow registers and per-alignment trace state
    // ------------------------------------------------------------------
    logic [30:0]        cfg_start  = '0;
    logic signed [31:0] cfg_offset = '0;
    logic [31:0]        cfg_qid    = '0;

    logic signed [31:0] trace_cursor = 32'hFFFF_FFFF;   // start - 1 with start = 0
    logic [3:0]         trace_run    = '0;
    logic signed [31:0] trace_prev   = 32'hFFFF_FFFF;
    logic [3:0]         trace_prev_run  = '0;
    logic [7:0]         trace_prev_char = DOT_CHAR;
    bit                 trace_halted = 1'b0;

    t_column     column_queue [$];   // columns waiting for the driver
    t_result     pending_tags [$];   // tags predicted, not yet seen
    t_column     live_column;
    int unsigned cols_popped = 0;
    int unsigned cols_taken  = 0;
    int unsigned send_gap    = 0;
    int unsigned stall_left  = 0;
    int unsigned calm_left [2] = '{0, 0};
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // Works out the tags for one accepted column and queues them.
    function automatic void tag_column(input t_column c);
        t_result tag;
        longint  pos;
        if (c.first_column) begin
            trace_cursor    = {1'b0, cfg_start} - 32'd1;
            trace_run       = '0;
            trace_prev      = 32'hFFFF_FFFF;
            trace_prev_run  = '0;
            trace_prev_char = DOT_CHAR;
            trace_halted    = 1'b0;
        end
        if (trace_halted) return;

        if (c.query_char != GAP_CHAR && trace_run < INSERT_CAP) trace_run = trace_run + 4'd1;
        if (c.target_char != GAP_CHAR) begin
            trace_cursor = trace_cursor + 32'sd1;   // wraps in 32 bits
            trace_run    = '0;
        end

        // exact sum; a negative position ends tagging with a lone marker
        pos = longint'(trace_cursor) + longint'(cfg_offset);
        if (pos < 0) begin
            pending_tags.push_back(END_TAG);
            trace_halted = 1'b1;
            return;
        end

        tag.tag_target_pos  = pos[31:0];
        tag.tag_delta       = {4'd0, trace_run};
        tag.prev_target_pos = trace_prev + cfg_offset;
        tag.prev_delta      = trace_prev_run;
        tag.prev_base       = trace_prev_char;
        tag.cur_base        = c.query_char;
        tag.tag_query_id    = cfg_qid;
        tag.is_sentinel     = 1'b0;
        tag.last_result     = !c.last_column;
        pending_tags.push_back(tag);

        trace_prev      = trace_cursor;
        trace_prev_run  = trace_run;
        trace_prev_char = c.query_char;

        if (c.last_column) begin
            pending_tags.push_back(END_TAG);
            trace_halted = 1'b1;
        end
    endfunction

    // Idle length for one side (0 = sender, 1 = receiver): mostly none or
    // short, now and then long, with occasional stretches of no idling.
    function automatic int unsigned idle_len(input int side);
        int unsigned r;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm_left[side] = $urandom_range(20, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit field_ok(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
        if (want === got) return 1'b1;
        if (mismatches < 10)
            $display("%0t tag mismatch %s: expected %h got %h", $realtime, name, want, got);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Column driver: one beat per handshake, random gaps between beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                tag_column(live_column);
                cols_taken++;
            end
            // payload holds while stalled
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (column_queue.size() > 0) begin
                    live_column = column_queue.pop_front();
                    cols_popped++;
                    i_query_char   <= live_column.query_char;
                    i_target_char  <= live_column.target_char;
                    i_first_column <= live_column.first_column;
                    i_last_column  <= live_column.last_column;
                    i_in_valid     <= 1'b1;
                    send_gap = idle_len(0);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tag monitor: compares each accepted beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        bit      ok;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen.tag_target_pos  = o_tag_target_pos;
                seen.tag_delta       = o_tag_delta;
                seen.prev_target_pos = o_prev_target_pos;
                seen.prev_delta      = o_prev_delta;
                seen.prev_base       = o_prev_base;
                seen.cur_base        = o_cur_base;
                seen.tag_query_id    = o_tag_query_id;
                seen.is_sentinel     = o_is_sentinel;
                seen.last_result     = o_last_result;
                if (pending_tags.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t unexpected tag beat, target pos %h", $realtime,
                                 seen.tag_target_pos);
                    mismatches++;
                end else begin
                    want = pending_tags.pop_front();
                    ok = field_ok("tag_target_pos", want.tag_target_pos, seen.tag_target_pos)
                       & field_ok("tag_delta", 32'(want.tag_delta), 32'(seen.tag_delta))
                       & field_ok("prev_target_pos", want.prev_target_pos,
                                  seen.prev_target_pos)
                       & field_ok("prev_delta", 32'(want.prev_delta), 32'(seen.prev_delta))
                       & field_ok("prev_base", 32'(want.prev_base), 32'(seen.prev_base))
                       & field_ok("cur_base", 32'(want.cur_base), 32'(seen.cur_base))
                       & field_ok("tag_query_id", want.tag_query_id, seen.tag_query_id)
                       & field_ok("is_sentinel", 32'(want.is_sentinel), 32'(seen.is_sentinel))
                       & field_ok("last_result", 32'(want.last_result), 32'(seen.last_result));
                    if (!ok) mismatches++;
                end
            end
            // stall sequence: open, then a random stall run
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = idle_len(1);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_alignment_column_tagger_unit: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Register write; the shadow copy changes at the handshake edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TARGET_START:  cfg_start  = data[30:0];
            CFG_TARGET_OFFSET: cfg_offset = data;
            CFG_QUERY_ID:      cfg_qid    = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sender holds off until every column is taken and every tag has come.
    task automatic drain();
        while (!(column_queue.size() == 0 && cols_taken == cols_popped
                 && pending_tags.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_col(input logic [7:0] q, input logic [7:0] t,
                                     input bit first, input bit last);
        t_column c;
        c.query_char   = q;
        c.target_char  = t;
        c.first_column = first;
        c.last_column  = last;
        column_queue.push_back(c);
    endfunction

    function automatic logic [7:0] pick_base(input int unsigned gap_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < gap_pct) return GAP_CHAR;
        if (r < 95) begin
            case ($urandom_range(0, 3))
                0: return BASE_A;
                1: return BASE_C;
                2: return BASE_G;
                default: return BASE_T;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed alignments with random content; some strays outside
    // any alignment, some with no closing column, some restarted midway.
    task automatic add_alignments(input int unsigned budget);
        int unsigned added;
        int unsigned shape;
        int unsigned len;
        int unsigned qgap;
        int unsigned tgap;
        added = 0;
        while (added < budget) begin
            shape = $urandom_range(0, 99);
            if (shape < 6) begin
                push_col(pick_base(20), pick_base(20), 1'b0, 1'($urandom_range(0, 1)));
                continue;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                              : $urandom_range(1, 24);
            case ($urandom_range(0, 2))
                0: qgap = 5;
                1: qgap = 20;
                default: qgap = 50;
            endcase
            // high target gap rate builds long insertion runs past the cap
            case ($urandom_range(0, 2))
                0: tgap = 5;
                1: tgap = 30;
                default: tgap = 90;
            endcase
            for (int unsigned i = 0; i < len; i++) begin
                push_col(pick_base(qgap), pick_base(tgap),
                         i == 0 || (shape >= 14 && shape < 18 && i == len / 2),
                         i == len - 1 && shape >= 10);
                added++;
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] start, input logic [31:0] offset,
                             input logic [31:0] qid, input int unsigned budget);
        write_reg(CFG_TARGET_START, start);
        write_reg(CFG_TARGET_OFFSET, offset);
        write_reg(CFG_QUERY_ID, qid);
        add_alignments(budget);
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, on reset settings (start 0, offset 0, id 0).
        push_col(8'h00, GAP_CHAR, 1'b0, 1'b0);   // before any first column: cursor -1, marker
        push_col(BASE_A, BASE_C, 1'b0, 1'b0);    // halted, dropped
        push_col(BASE_G, BASE_T, 1'b1, 1'b0);    // reload, position 0
        repeat (14) push_col(BASE_A, GAP_CHAR, 1'b0, 1'b0);   // insertion run saturates
        push_col(GAP_CHAR, GAP_CHAR, 1'b0, 1'b0);
        push_col(8'hFF, 8'hFF, 1'b0, 1'b0);
        push_col(GAP_CHAR, BASE_A, 1'b0, 1'b1);  // last: tag then marker
        push_col(BASE_C, GAP_CHAR, 1'b1, 1'b1);  // negative beats last: marker only
        push_col(BASE_T, BASE_A, 1'b1, 1'b1);    // one-column alignment
        drain();

        write_reg(CFG_SPARE, 32'hDEAD_BEEF);     // unmapped index must be dropped
        run_phase(32'd1, 32'd0, 32'd0, 90);
        // top of range: positions near 2^32, previous position wraps
        run_phase(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 90);
        // most negative offset: every alignment ends on its first column
        run_phase(32'd0, 32'h8000_0000, 32'h5A5A_A5A5, 40);
        // cursor crosses 2^31 and wraps negative in long alignments
        run_phase(32'h7FFF_FFF0, 32'd100, $urandom, 90);
        // offset -1: first column without a target base goes negative
        run_phase(32'd1, 32'hFFFF_FFFF, $urandom, 90);
        repeat (5)
            run_phase($urandom_range(1, 5000), 32'(int'($urandom_range(0, 1000)) - 300),
                      $urandom, 90);

        if (mismatches == 0 && pending_tags.size() == 0) begin
            $display("tb_alignment_column_tagger_unit: PASS");
        end else begin
            $display("tb_alignment_column_tagger_unit: FAIL");
        end
        $finish;
    end

endmodule
